@@ rtl/core/rrd_pkg.sv @@
// Shared types and codes of the roll response decoder.
package rrd_pkg;

   localparam logic [2:0] KIND_ID_BYTE  = 3'd0;
   localparam logic [2:0] KIND_ROLL     = 3'd1;
   localparam logic [2:0] KIND_DICE     = 3'd2;
   localparam logic [2:0] KIND_TOTAL    = 3'd3;
   localparam logic [2:0] KIND_MODIFIER = 3'd4;
   localparam logic [2:0] KIND_STATUS   = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_ROLL   = 3'd1;
   localparam logic [2:0] ST_TRUNCATED = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_OVERRUN   = 3'd4;

   localparam logic [2:0] WT_VARINT = 3'd0;
   localparam logic [2:0] WT_LEN    = 3'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic [2:0]         status;
      logic               last_result;
   } rsp_type;

endpackage

@@ rtl/core/rrd_front.sv @@
// Byte parser: decodes tags and varints and produces up to two results per request.
module rrd_front #(
   parameter int LENGTH_BITS      = 32,
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  rrd_pkg::req_type req,
   output logic [1:0]      push_count,
   output rrd_pkg::rsp_type push0,
   output rrd_pkg::rsp_type push1
);
   import rrd_pkg::*;

   typedef enum logic [3:0] {
      OUT_TAG, OUT_LEN, OUT_VAL, OUT_SKIP,
      IN_TAG, IN_LEN, IN_VAL, IN_ID, IN_SKIP, IN_DICE, DRAIN
   } phase_type;

   localparam int CW = 4;

   phase_type              phase_ff, phase_in;
   logic [63:0]            acc_ff, acc_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [28:0]            fn_ff, fn_in;
   logic [2:0]             wk_ff, wk_in;
   logic [LENGTH_BITS-1:0] nest_ff, nest_in, span_ff, span_in;
   logic                   seen_ff, seen_in;
   logic [2:0]             err_ff, err_in;

   logic [70:0]   shifted;
   logic [63:0]   tv;
   logic [CW-1:0] cnt_next;
   logic          vdone, vlong;

   always_comb begin
      shifted  = 71'(req.data_byte[6:0]) << (7'(cnt_ff) * 7'd7);
      tv       = (cnt_ff <= CW'(9)) ? (acc_ff | shifted[63:0]) : acc_ff;
      cnt_next = cnt_ff + CW'(1);
      vdone    = !req.data_byte[7];
      vlong    = req.data_byte[7] && (cnt_next >= CW'(MAX_VARINT_BYTES));
   end

   function automatic rsp_type mk(logic [2:0] k, logic [31:0] v, logic [2:0] s, logic l);
      rsp_type r;
      r.kind = k; r.value = v; r.status = s; r.last_result = l;
      return r;
   endfunction

   always_comb begin
      logic [63:0] f;
      logic [28:0] fn;
      logic [2:0]  wt;
      logic        in_roll, wide, inner;
      logic [2:0]  code;
      rsp_type     r0, r1;
      logic [1:0]  n;

      phase_in = phase_ff; acc_in = acc_ff; cnt_in = cnt_ff; fn_in = fn_ff; wk_in = wk_ff;
      nest_in = nest_ff; span_in = span_ff; seen_in = seen_ff; err_in = err_ff;
      r0 = mk(KIND_ID_BYTE, 32'd0, ST_OK, 1'b0);
      r1 = r0;
      n = 2'd0;
      f = tv >> 3;
      fn = (f > 64'h1FFFFFFF) ? 29'd0 : f[28:0];
      wt = tv[2:0];
      wide = (tv >> LENGTH_BITS) != 64'd0;
      inner = (phase_ff == IN_TAG);
      code = ST_OK;

      in_roll = phase_ff >= IN_TAG && phase_ff <= IN_DICE;
      if (in_roll && nest_ff != '0) nest_in = nest_ff - LENGTH_BITS'(1);

      // advance the varint for every phase that takes one
      if (phase_ff == OUT_TAG || phase_ff == IN_TAG || phase_ff == OUT_LEN ||
          phase_ff == OUT_VAL || phase_ff == IN_LEN || phase_ff == IN_VAL ||
          phase_ff == IN_DICE) begin
         if (vdone) begin
            acc_in = '0; cnt_in = '0;
         end else begin
            acc_in = tv; cnt_in = cnt_next;
         end
      end

      unique case (phase_ff)
         OUT_TAG, IN_TAG: begin
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else if (vdone) begin
               fn_in = fn; wk_in = wt;
               if (!inner) begin
                  if (fn == 29'd1)
                     phase_in = (wt == WT_LEN) ? OUT_LEN : OUT_TAG;
                  else if (fn == 29'd2)
                     phase_in = (wt == WT_VARINT) ? OUT_VAL : OUT_TAG;
                  else
                     phase_in = (wt == WT_VARINT) ? OUT_VAL :
                                (wt == WT_LEN) ? OUT_LEN : OUT_TAG;
               end else begin
                  if (fn == 29'd1 || fn == 29'd2 || fn == 29'd3)
                     phase_in = (wt == WT_LEN) ? IN_LEN : IN_TAG;
                  else if (fn == 29'd4 || fn == 29'd8)
                     phase_in = (wt == WT_VARINT) ? IN_VAL : IN_TAG;
                  else
                     phase_in = (wt == WT_VARINT) ? IN_VAL :
                                (wt == WT_LEN) ? IN_LEN : IN_TAG;
               end
            end
         end
         OUT_LEN: begin
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else if (vdone) begin
               if (wide) begin
                  err_in = ST_OVERRUN; phase_in = DRAIN;
               end else if (fn_ff == 29'd1) begin
                  r0 = mk(KIND_ROLL, tv[31:0], ST_OK, 1'b0); n = 2'd1;
                  if (tv == 64'd0) begin
                     seen_in = 1'b1; phase_in = OUT_TAG;
                  end else begin
                     nest_in = tv[LENGTH_BITS-1:0]; phase_in = IN_TAG;
                  end
               end else if (tv == 64'd0) begin
                  phase_in = OUT_TAG;
               end else begin
                  span_in = tv[LENGTH_BITS-1:0]; phase_in = OUT_SKIP;
               end
            end
         end
         OUT_VAL: begin
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else if (vdone) phase_in = OUT_TAG;
         end
         OUT_SKIP: begin
            if (span_ff <= LENGTH_BITS'(1)) begin
               span_in = '0; phase_in = OUT_TAG;
            end else span_in = span_ff - LENGTH_BITS'(1);
         end
         IN_LEN: begin
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else if (vdone) begin
               if (wide || tv > 64'(nest_in)) begin
                  err_in = ST_OVERRUN; phase_in = DRAIN;
               end else if (tv == 64'd0) phase_in = IN_TAG;
               else begin
                  span_in = tv[LENGTH_BITS-1:0];
                  phase_in = (fn_ff == 29'd1) ? IN_ID : (fn_ff == 29'd3) ? IN_DICE : IN_SKIP;
               end
            end
         end
         IN_VAL: begin
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else if (vdone) begin
               if (fn_ff == 29'd4) begin
                  r0 = mk(KIND_TOTAL, tv[31:0], ST_OK, 1'b0); n = 2'd1;
               end else if (fn_ff == 29'd8) begin
                  r0 = mk(KIND_MODIFIER, tv[31:0], ST_OK, 1'b0); n = 2'd1;
               end
               phase_in = IN_TAG;
            end
         end
         IN_ID, IN_SKIP: begin
            if (phase_ff == IN_ID) begin
               r0 = mk(KIND_ID_BYTE, 32'(req.data_byte), ST_OK, 1'b0); n = 2'd1;
            end
            if (span_ff <= LENGTH_BITS'(1)) begin
               span_in = '0; phase_in = IN_TAG;
            end else span_in = span_ff - LENGTH_BITS'(1);
         end
         IN_DICE: begin
            if (span_ff != '0) span_in = span_ff - LENGTH_BITS'(1);
            if (vlong) begin
               err_in = ST_TOO_LONG; phase_in = DRAIN;
            end else begin
               if (vdone) begin
                  r0 = mk(KIND_DICE, tv[31:0], ST_OK, 1'b0); n = 2'd1;
               end
               if (span_in == '0) begin
                  if (!vdone) begin
                     err_in = ST_TRUNCATED; phase_in = DRAIN;
                  end else phase_in = IN_TAG;
               end
            end
         end
         default: ;
      endcase

      // close the roll message once its length is used up, or flag a cut-off item
      if (phase_in >= IN_TAG && phase_in <= IN_DICE && nest_in == '0) begin
         if (phase_in == IN_TAG && cnt_in == '0) begin
            seen_in = 1'b1; phase_in = OUT_TAG;
         end else begin
            err_in = ST_TRUNCATED; phase_in = DRAIN;
         end
      end

      if (req.final_byte) begin
         if (err_in != ST_OK) code = err_in;
         else if (phase_in == OUT_TAG && cnt_in == '0) code = seen_in ? ST_OK : ST_NO_ROLL;
         else if ((phase_in >= IN_TAG && phase_in <= IN_DICE) || phase_in == OUT_SKIP)
            code = ST_OVERRUN;
         else code = ST_TRUNCATED;
         if (n == 2'd0) r0 = mk(KIND_STATUS, 32'(code), code, 1'b1);
         else r1 = mk(KIND_STATUS, 32'(code), code, 1'b1);
         n = n + 2'd1;
         phase_in = OUT_TAG; acc_in = '0; cnt_in = '0; fn_in = '0; wk_in = '0;
         nest_in = '0; span_in = '0; seen_in = 1'b0; err_in = ST_OK;
      end

      push0 = r0;
      push1 = r1;
      push_count = take ? n : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= OUT_TAG; acc_ff <= '0; cnt_ff <= '0; fn_ff <= '0; wk_ff <= '0;
         nest_ff <= '0; span_ff <= '0; seen_ff <= 1'b0; err_ff <= ST_OK;
      end else if (take) begin
         phase_ff <= phase_in; acc_ff <= acc_in; cnt_ff <= cnt_in; fn_ff <= fn_in;
         wk_ff <= wk_in; nest_ff <= nest_in; span_ff <= span_in; seen_ff <= seen_in;
         err_ff <= err_in;
      end
   end
endmodule

@@ rtl/core/rrd_queue.sv @@
// Four-entry result queue: takes up to two results a cycle and hands out one while rsp_stall is low.
module rrd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  rrd_pkg::rsp_type push0,
   input  rrd_pkg::rsp_type push1,
   output logic             has_room,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rrd_pkg::rsp_type rsp_data
);
   import rrd_pkg::*;

   rsp_type    slot_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;
   logic       pop;

   assign rsp_valid = count_ff != 3'd0;
   assign rsp_data  = slot_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign has_room  = count_ff <= 3'd2;

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) slot_ff[wr_ff] <= push0;
      if (push_count == 2'd2) slot_ff[wr_ff + 2'd1] <= push1;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; count_ff <= '0;
      end else begin
         wr_ff    <= wr_ff + push_count;
         rd_ff    <= rd_ff + 2'(pop);
         count_ff <= count_ff + 3'(push_count) - 3'(pop);
      end
   end
endmodule

@@ rtl/core/protobuf_roll_response_decoder.sv @@
// Top level of the protobuf roll response decoder.
// Takes one byte request per cycle while not stalled and emits roll events: roll
// start (value is the nested length), id bytes, packed dice values, total and
// modifier, and on the final byte a status result (ok, no roll, truncated,
// varint too long, overrun) with last_result set. The parser accepts a request
// every cycle while the result queue has room for two results; results leave
// at one per cycle, so bursts of id or dice bytes that produce a result per
// byte plus a status sustain one request per cycle, and the output port sets
// the rate when it stalls.
module protobuf_roll_response_decoder #(
   parameter int LENGTH_BITS      = 32,
   parameter int MAX_VARINT_BYTES = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rrd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rrd_pkg::rsp_type rsp_data
);
   import rrd_pkg::*;

   logic       room, take;
   logic [1:0] push_count;
   rsp_type    push0, push1;

   // stall requests until the queue can hold the worst case of two results
   assign req_stall = !room;
   assign take      = req_valid && room;

   rrd_front #(.LENGTH_BITS(LENGTH_BITS), .MAX_VARINT_BYTES(MAX_VARINT_BYTES)) u_front (
      .clock(clock), .reset(reset), .take(take), .req(req_data),
      .push_count(push_count), .push0(push0), .push1(push1)
   );

   rrd_queue u_queue (
      .clock(clock), .reset(reset), .push_count(push_count), .push0(push0),
      .push1(push1), .has_room(room), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );
endmodule

@@ sim/rrd_checker.sv @@
// Checker for the roll response decoder: predicts results and compares them.
`timescale 1ns / 100ps
module rrd_checker
   import rrd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      result_count,
   output int      buffer_count
);

   localparam int LEN_BITS   = 32;
   localparam int MAX_VBYTES = 10;

   typedef enum logic [3:0] {
      P_OUT_TAG, P_OUT_LEN, P_OUT_VAL, P_OUT_SKIP, P_IN_TAG, P_IN_LEN,
      P_IN_VAL, P_IN_ID, P_IN_SKIP, P_IN_DICE, P_DRAIN
   } phase_type;

   typedef enum int { V_MORE, V_DONE, V_LONG } vstate_type;

   phase_type   phase;
   logic [63:0] accum;
   int unsigned vcount;
   logic [31:0] field_no;
   logic [2:0]  wtype;
   logic [31:0] roll_left;
   logic [31:0] span_left;
   logic        rolled;
   logic [2:0]  err_code;

   rsp_type expected_q[$];

   function automatic bit in_roll_phase(phase_type p);
      return p >= P_IN_TAG && p <= P_IN_DICE;
   endfunction

   task automatic clear_parser();
      phase = P_OUT_TAG; accum = '0; vcount = 0; field_no = '0; wtype = '0;
      roll_left = '0; span_left = '0; rolled = 1'b0; err_code = '0;
   endtask

   function automatic vstate_type absorb_byte(logic [7:0] b);
      int unsigned sh;
      sh = vcount * 7;
      if (sh < 64) accum = accum | (64'(b[6:0]) << sh);
      vcount++;
      if (!b[7]) return V_DONE;
      if (vcount >= MAX_VBYTES) return V_LONG;
      return V_MORE;
   endfunction

   function automatic logic [63:0] take_value();
      logic [63:0] v;
      v = accum; accum = '0; vcount = 0;
      return v;
   endfunction

   task automatic raise_error(logic [2:0] code);
      err_code = code; phase = P_DRAIN;
   endtask

   task automatic push_event(logic [2:0] kind, logic [31:0] value,
                             logic [2:0] status = ST_OK, logic last = 1'b0);
      rsp_type r;
      r.kind = kind; r.value = value; r.status = status; r.last_result = last;
      expected_q.push_back(r);
   endtask

   task automatic route_tag(logic [63:0] tag, bit inner);
      logic [60:0] f;
      logic [31:0] fn;
      logic [2:0]  wt;
      f  = tag[63:3];
      fn = (f > 61'h1FFF_FFFF) ? 32'd0 : 32'(f);
      wt = tag[2:0];
      field_no = fn; wtype = wt;
      if (!inner) begin
         if (fn == 1)      phase = (wt == WT_LEN) ? P_OUT_LEN : P_OUT_TAG;
         else if (fn == 2) phase = (wt == WT_VARINT) ? P_OUT_VAL : P_OUT_TAG;
         else phase = (wt == WT_VARINT) ? P_OUT_VAL : (wt == WT_LEN) ? P_OUT_LEN : P_OUT_TAG;
      end else begin
         if (fn == 1 || fn == 2 || fn == 3) phase = (wt == WT_LEN) ? P_IN_LEN : P_IN_TAG;
         else if (fn == 4 || fn == 8) phase = (wt == WT_VARINT) ? P_IN_VAL : P_IN_TAG;
         else phase = (wt == WT_VARINT) ? P_IN_VAL : (wt == WT_LEN) ? P_IN_LEN : P_IN_TAG;
      end
   endtask

   // Advance the decoder prediction by one request.
   task automatic decode_byte(logic [7:0] b, logic fin);
      vstate_type  r;
      logic [63:0] v;
      logic [2:0]  code;
      if (in_roll_phase(phase) && roll_left != 0) roll_left--;
      case (phase)
         P_OUT_TAG, P_IN_TAG: begin
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else if (r == V_DONE) route_tag(take_value(), phase == P_IN_TAG);
         end
         P_OUT_LEN: begin
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else if (r == V_DONE) begin
               v = take_value();
               if ((v >> LEN_BITS) != 0) raise_error(ST_OVERRUN);
               else if (field_no == 1) begin
                  push_event(KIND_ROLL, v[31:0]);
                  if (v == 0) begin
                     rolled = 1'b1; phase = P_OUT_TAG;
                  end else begin
                     roll_left = v[31:0]; phase = P_IN_TAG;
                  end
               end else if (v == 0) phase = P_OUT_TAG;
               else begin
                  span_left = v[31:0]; phase = P_OUT_SKIP;
               end
            end
         end
         P_OUT_VAL: begin
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else if (r == V_DONE) begin
               v = take_value(); phase = P_OUT_TAG;
            end
         end
         P_OUT_SKIP: begin
            if (span_left != 0) span_left--;
            if (span_left == 0) phase = P_OUT_TAG;
         end
         P_IN_LEN: begin
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else if (r == V_DONE) begin
               v = take_value();
               if ((v >> LEN_BITS) != 0 || v > 64'(roll_left)) raise_error(ST_OVERRUN);
               else if (v == 0) phase = P_IN_TAG;
               else begin
                  span_left = v[31:0];
                  phase = (field_no == 1) ? P_IN_ID : (field_no == 3) ? P_IN_DICE : P_IN_SKIP;
               end
            end
         end
         P_IN_VAL: begin
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else if (r == V_DONE) begin
               v = take_value();
               if (field_no == 4) push_event(KIND_TOTAL, v[31:0]);
               else if (field_no == 8) push_event(KIND_MODIFIER, v[31:0]);
               phase = P_IN_TAG;
            end
         end
         P_IN_ID, P_IN_SKIP: begin
            if (phase == P_IN_ID) push_event(KIND_ID_BYTE, 32'(b));
            if (span_left != 0) span_left--;
            if (span_left == 0) phase = P_IN_TAG;
         end
         P_IN_DICE: begin
            if (span_left != 0) span_left--;
            r = absorb_byte(b);
            if (r == V_LONG) raise_error(ST_TOO_LONG);
            else begin
               if (r == V_DONE) begin
                  v = take_value();
                  push_event(KIND_DICE, v[31:0]);
               end
               if (span_left == 0) begin
                  if (r == V_MORE) raise_error(ST_TRUNCATED);
                  else phase = P_IN_TAG;
               end
            end
         end
         default: ;
      endcase
      // The roll message has used up its length: close it or flag a cut-off item.
      if (in_roll_phase(phase) && roll_left == 0) begin
         if (phase == P_IN_TAG && vcount == 0) begin
            rolled = 1'b1; phase = P_OUT_TAG;
         end else raise_error(ST_TRUNCATED);
      end
      if (fin) begin
         if (err_code != 0) code = err_code;
         else if (phase == P_OUT_TAG && vcount == 0) code = rolled ? ST_OK : ST_NO_ROLL;
         else if (in_roll_phase(phase) || phase == P_OUT_SKIP) code = ST_OVERRUN;
         else code = ST_TRUNCATED;
         push_event(KIND_STATUS, 32'(code), code, 1'b1);
         clear_parser();
      end
   endtask

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         clear_parser();
         expected_q.delete();
         fail_count   <= 0;
         result_count <= 0;
         buffer_count <= 0;
      end else begin
         // Compare results first, then predict, so same-edge updates cannot mix.
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result kind=%0d value=%0d status=%0d last=%0b",
                           rsp_data.kind, rsp_data.value, rsp_data.status,
                           rsp_data.last_result);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r !== rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: expected kind=%0d value=%0d status=%0d last=%0b, %s",
                              exp_r.kind, exp_r.value, exp_r.status, exp_r.last_result,
                              $sformatf("got kind=%0d value=%0d status=%0d last=%0b",
                                        rsp_data.kind, rsp_data.value, rsp_data.status,
                                        rsp_data.last_result));
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data.data_byte, req_data.final_byte);
            if (req_data.final_byte) buffer_count <= buffer_count + 1;
         end
      end
   end

endmodule

@@ sim/tb_protobuf_roll_response_decoder.sv @@
// Testbench top for the roll response decoder: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_protobuf_roll_response_decoder;
   import rrd_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count, pending_count, result_count, buffer_count;
   int send_idle_pct = 25;
   int recv_idle_pct = 46;
   int sent_count = 0;
   int cycle_count = 0;

   // Byte buffer under construction, sent as one response.
   logic [7:0] msg[$];

   always #5 clock = ~clock;

   protobuf_roll_response_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   rrd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count), .buffer_count(buffer_count)
   );

   // Stall the result side at random; change only at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_protobuf_roll_response_decoder failed");
         $finish;
      end
   end

   // Drive one request and hold it until accepted; insert random idle cycles first.
   // Valid stays high afterwards so the next request can follow with no gap.
   task automatic send_byte(logic [7:0] b, logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, final_byte: fin};
      do @(posedge clock); while (req_stall);
      sent_count++;
      @(negedge clock);
   endtask

   // Send the whole buffer, final flag on its last byte.
   task automatic send_msg();
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
      msg.delete();
   endtask

   task automatic add_varint(logic [63:0] v);
      do begin
         msg.push_back({(v >> 7) != 0, v[6:0]});
         v = v >> 7;
      end while (v != 0);
   endtask

   function automatic logic [63:0] rand_value();
      case ($urandom_range(3))
         0: return 64'($urandom_range(20));
         1: return 64'($urandom);
         2: return {$urandom, $urandom};
         default: return 64'($urandom_range(300));
      endcase
   endfunction

   // Build a random roll message body, mostly well formed.
   task automatic build_roll(output logic [7:0] body[$]);
      logic [7:0] save[$];
      int n;
      save = msg;
      msg.delete();
      repeat ($urandom_range(4)) begin
         case ($urandom_range(6))
            0: begin
               n = $urandom_range(1, 6);
               add_varint(64'h0A); add_varint(64'(n));
               repeat (n) msg.push_back(8'($urandom));
            end
            1: begin
               add_varint(64'h12); add_varint(64'd2); msg.push_back("2"); msg.push_back("d");
            end
            2: begin
               logic [7:0] d[$];
               logic [7:0] hold[$];
               hold = msg; msg.delete();
               repeat ($urandom_range(1, 3)) add_varint(rand_value());
               d = msg; msg = hold;
               add_varint(64'h1A); add_varint(64'(d.size()));
               foreach (d[i]) msg.push_back(d[i]);
            end
            3: begin add_varint(64'h20); add_varint(rand_value()); end
            4: begin add_varint(64'h40); add_varint(rand_value()); end
            5: begin add_varint(64'h28); add_varint(rand_value()); end
            default: begin add_varint(64'h32); add_varint(64'd1); msg.push_back(8'h55); end
         endcase
      end
      body = msg;
      msg = save;
   endtask

   task automatic random_buffer();
      logic [7:0] body[$];
      int k;
      repeat ($urandom_range(1, 3)) begin
         k = $urandom_range(9);
         if (k < 6) begin
            build_roll(body);
            add_varint(64'h0A); add_varint(64'(body.size()));
            foreach (body[i]) msg.push_back(body[i]);
         end else if (k == 6) begin
            add_varint(64'h10); add_varint(rand_value());
         end else if (k == 7) begin
            add_varint(64'h1A); add_varint(64'd2); msg.push_back(8'h01); msg.push_back(8'h02);
         end else begin
            // Noise: raw random bytes.
            repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
         end
      end
      // Sometimes chop the buffer short to hit truncation and overrun ends.
      if (msg.size() > 1 && $urandom_range(9) == 0)
         msg = msg[0:$urandom_range(msg.size() - 2)];
      if (msg.size() == 0) msg.push_back(8'h00);
      send_msg();
   endtask

   // Drop valid and wait until every expected result has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: one roll with id, dice and total.
      add_varint(64'h0A); add_varint(64'd20);
      add_varint(64'h0A); add_varint(64'd2); msg.push_back(8'hFF); msg.push_back(8'h00);
      add_varint(64'h1A); add_varint(64'd3); msg.push_back(8'h81); msg.push_back(8'h01);
      msg.push_back(8'h7F);
      add_varint(64'h20); add_varint(64'hFFFF_FFFF_FFFF_FFFF);
      send_msg();
      // Empty roll, then no roll at all.
      add_varint(64'h0A); add_varint(64'd0); send_msg();
      add_varint(64'h10); add_varint(64'd5); send_msg();
      // Varint too long, truncated tag, overrun length.
      repeat (10) msg.push_back(8'hFF); send_msg();
      msg.push_back(8'h80); send_msg();
      add_varint(64'h0A); add_varint(64'd5); msg.push_back(8'h08); send_msg();
      add_varint(64'h0A); add_varint(64'h1_0000_0000); send_msg();
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 46 : 0;
         recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 25 : 0;
         for (int start = sent_count; sent_count < start + 70; ) random_buffer();
         // Hold off until every expected result has come.
         wait_drained();
      end

      repeat (20) @(negedge clock);
      $display("sent %0d requests in %0d buffers, checked %0d results",
               sent_count, buffer_count, result_count);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_protobuf_roll_response_decoder passed");
      else
         $display("tb_protobuf_roll_response_decoder failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/rrd_pkg.sv
rtl/core/rrd_front.sv
rtl/core/rrd_queue.sv
rtl/core/protobuf_roll_response_decoder.sv
sim/rrd_checker.sv
sim/tb_protobuf_roll_response_decoder.sv
